@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

    localparam int COEF_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OUT_WIDTH       = 43;
    localparam int OUT_TDATA_WIDTH = ((2 * OUT_WIDTH + 7) / 8) * 8;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_NO_QUAD  = 2'd3
    } kind_t;

endpackage

@@ hw/rtl/quadratic_root_solver_core.sv @@
// Roots of a*x^2 + b*x + c. Each input transaction carries a, b and c; each output
// transaction carries the root kind and two signed values with FRAC_BITS fraction bits
// (two roots, or real part and imaginary term, which follows the sign of a). A new
// transaction is taken every cycle while the output side keeps up. The square root
// and the divider each resolve one result bit per pipeline stage. A four-entry
// queue lets the multiplier front end keep accepting while the output stalls briefly.
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
    localparam int IN_TDATA_WIDTH = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // coef_square, coef_linear, coef_constant
    input  logic [IN_TDATA_WIDTH-1:0]             s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // first_value, second_value
    output logic [qrs_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    // root_kind
    output logic [1:0]                            m_axis_tuser
);
    import qrs_pkg::*;

    localparam int CW  = COEF_WIDTH;
    localparam int NBW = CW + FRAC_BITS + 1;
    localparam int QW  = 2 + (2 * CW + 1) + NBW + 1 + (CW + 1);

    logic                   f_valid;
    logic                   f_ready;
    kind_t                  f_kind;
    logic [2*CW:0]          f_mag;
    logic signed [NBW-1:0]  f_negb;
    logic                   f_aneg;
    logic [CW:0]            f_den;

    logic                   q_valid;
    logic                   q_ready;
    logic [QW-1:0]          q_in;
    logic [QW-1:0]          q_out;

    kind_t                  b_kind;
    logic signed [OUT_WIDTH-1:0] b_first;
    logic signed [OUT_WIDTH-1:0] b_second;

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .coef_square   (s_axis_tdata[CW-1:0]),
        .coef_linear   (s_axis_tdata[2*CW-1:CW]),
        .coef_constant (s_axis_tdata[3*CW-1:2*CW]),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .kind          (f_kind),
        .disc_mag      (f_mag),
        .neg_lin       (f_negb),
        .square_neg    (f_aneg),
        .den_mag       (f_den)
    );

    assign q_in = {f_den, f_aneg, f_negb, f_mag, f_kind};

    qrs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    qrs_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .kind         (kind_t'(q_out[1:0])),
        .disc_mag     (q_out[2*CW+2:2]),
        .neg_lin      (q_out[2*CW+2+NBW:2*CW+3]),
        .square_neg   (q_out[2*CW+3+NBW]),
        .den_mag      (q_out[QW-1:2*CW+4+NBW]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .root_kind    (b_kind),
        .first_value  (b_first),
        .second_value (b_second)
    );

    assign m_axis_tuser = b_kind;
    assign m_axis_tdata = OUT_TDATA_WIDTH'({b_second, b_first});

endmodule

@@ hw/rtl/qrs_front.sv @@
module qrs_front #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COEF_WIDTH-1:0]      coef_square,
    input  logic signed [COEF_WIDTH-1:0]      coef_linear,
    input  logic signed [COEF_WIDTH-1:0]      coef_constant,
    output logic                              out_valid,
    input  logic                              out_ready,
    output qrs_pkg::kind_t                    kind,
    output logic [2*COEF_WIDTH:0]             disc_mag,
    output logic signed [COEF_WIDTH+FRAC_BITS:0] neg_lin,
    output logic                              square_neg,
    output logic [COEF_WIDTH:0]               den_mag
);
    import qrs_pkg::*;

    localparam int CW = COEF_WIDTH;
    localparam int DW = 2 * CW + 2;
    localparam int NBW = CW + FRAC_BITS + 1;

    logic                     v1_reg;
    logic signed [CW-1:0]     a_reg;
    logic signed [CW-1:0]     b_reg;
    logic signed [2*CW-1:0]   bb_reg;
    logic signed [2*CW-1:0]   ac_reg;

    logic                     v2_reg;
    kind_t                    kind_reg;
    logic [2*CW:0]            mag_reg;
    logic signed [NBW-1:0]    negb_reg;
    logic                     aneg_reg;
    logic [CW:0]              den_reg;

    logic                     adv;
    logic signed [DW-1:0]     disc;
    logic signed [DW-1:0]     disc_abs;
    logic signed [NBW-1:0]    b_ext;
    logic signed [CW:0]       a_ext;
    logic [CW:0]              a_abs;
    kind_t                    kind_next;

    assign adv      = !v2_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        disc     = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        disc_abs = disc[DW-1] ? -disc : disc;
        b_ext    = NBW'(b_reg);
        a_ext    = (CW+1)'(a_reg);
        a_abs    = a_ext[CW] ? (CW+1)'(-a_ext) : (CW+1)'(a_ext);
        priority if (a_reg == '0)
            kind_next = KIND_NO_QUAD;
        else if (disc[DW-1])
            kind_next = KIND_COMPLEX;
        else if (disc == '0)
            kind_next = KIND_EQUAL;
        else
            kind_next = KIND_DISTINCT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // one multiplier per product, registered before the subtract
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= coef_square;
            b_reg    <= coef_linear;
            bb_reg   <= coef_linear * coef_linear;
            ac_reg   <= coef_square * coef_constant;
            kind_reg <= kind_next;
            mag_reg  <= disc_abs[2*CW:0];
            negb_reg <= -(b_ext <<< FRAC_BITS);
            aneg_reg <= a_reg[CW-1];
            den_reg  <= a_abs << 1;
        end
    end

    assign out_valid  = v2_reg;
    assign kind       = kind_reg;
    assign disc_mag   = mag_reg;
    assign neg_lin    = negb_reg;
    assign square_neg = aneg_reg;
    assign den_mag    = den_reg;

endmodule

@@ hw/rtl/qrs_queue.sv @@
module qrs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNTW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

@@ hw/rtl/qrs_back.sv @@
module qrs_back #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  qrs_pkg::kind_t                       kind,
    input  logic [2*COEF_WIDTH:0]                disc_mag,
    input  logic signed [COEF_WIDTH+FRAC_BITS:0] neg_lin,
    input  logic                                 square_neg,
    input  logic [COEF_WIDTH:0]                  den_mag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output qrs_pkg::kind_t                       root_kind,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value
);
    import qrs_pkg::*;

    localparam int CW  = COEF_WIDTH;
    localparam int NBW = CW + FRAC_BITS + 1;
    localparam int SW  = CW + FRAC_BITS + 1;        // root bits
    localparam int RW  = 2 * SW;                    // radicand bits
    localparam int RMW = SW + 2;                    // partial remainder bits
    localparam int NMW = SW + 1;                    // numerator magnitude bits
    localparam int NSW = NMW + 1;
    localparam int CMW = ((NMW > OUT_WIDTH) ? NMW : OUT_WIDTH) + 1;

    logic adv;

    // square root stages
    logic              sq_v_reg    [SW+1];
    kind_t             sq_kind_reg [SW+1];
    logic [RW-1:0]     sq_rad_reg  [SW+1];
    logic [RMW-1:0]    sq_rem_reg  [SW+1];
    logic [SW-1:0]     sq_root_reg [SW+1];
    logic signed [NBW-1:0] sq_negb_reg [SW+1];
    logic              sq_aneg_reg [SW+1];
    logic [CW:0]       sq_den_reg  [SW+1];

    logic [RW-1:0]     sq_rad_next  [SW];
    logic [RMW-1:0]    sq_rem_next  [SW];
    logic [SW-1:0]     sq_root_next [SW];

    // divider stages, quotient bits shift in behind the dividend
    logic              dv_v_reg    [NMW+1];
    kind_t             dv_kind_reg [NMW+1];
    logic [NMW-1:0]    dv_n1_reg   [NMW+1];
    logic [NMW-1:0]    dv_n2_reg   [NMW+1];
    logic [CW:0]       dv_r1_reg   [NMW+1];
    logic [CW:0]       dv_r2_reg   [NMW+1];
    logic              dv_s1_reg   [NMW+1];
    logic              dv_s2_reg   [NMW+1];
    logic [CW:0]       dv_den_reg  [NMW+1];

    logic [NMW-1:0]    dv_n1_next  [NMW];
    logic [NMW-1:0]    dv_n2_next  [NMW];
    logic [CW:0]       dv_r1_next  [NMW];
    logic [CW:0]       dv_r2_next  [NMW];

    logic signed [NSW-1:0] num1;
    logic signed [NSW-1:0] num2;
    logic signed [NSW-1:0] negb_ext;
    logic signed [NSW-1:0] root_ext;

    logic                  out_v_reg;
    kind_t                 out_kind_reg;
    logic signed [OUT_WIDTH-1:0] out_first_reg;
    logic signed [OUT_WIDTH-1:0] out_second_reg;
    logic signed [OUT_WIDTH-1:0] sat1;
    logic signed [OUT_WIDTH-1:0] sat2;

    function automatic logic signed [OUT_WIDTH-1:0] saturate(
        input logic [NMW-1:0] mag,
        input logic           neg
    );
        logic [CMW-1:0] m;
        logic [CMW-1:0] lim;
        logic [CMW-1:0] v;
        m   = CMW'(mag);
        lim = CMW'(1) << (OUT_WIDTH - 1);
        if (neg)
            v = (m > lim) ? -lim : -m;
        else
            v = (m > lim - 1'b1) ? lim - 1'b1 : m;
        return v[OUT_WIDTH-1:0];
    endfunction

    assign adv      = !out_v_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        logic [RMW+1:0] r;
        logic [RMW+1:0] trial;
        logic           ge;
        for (int k = 0; k < SW; k++)
        begin
            r     = {sq_rem_reg[k], sq_rad_reg[k][RW-1 -: 2]};
            trial = (RMW+2)'({sq_root_reg[k], 2'b01});
            ge    = r >= trial;
            sq_rem_next[k]  = ge ? RMW'(r - trial) : RMW'(r);
            sq_rad_next[k]  = sq_rad_reg[k] << 2;
            sq_root_next[k] = {sq_root_reg[k][SW-2:0], ge};
        end
    end

    always_comb
    begin
        logic [CW+1:0] r1;
        logic [CW+1:0] r2;
        logic [CW+1:0] d;
        logic          g1;
        logic          g2;
        for (int k = 0; k < NMW; k++)
        begin
            d  = {1'b0, dv_den_reg[k]};
            r1 = {dv_r1_reg[k], dv_n1_reg[k][NMW-1]};
            r2 = {dv_r2_reg[k], dv_n2_reg[k][NMW-1]};
            g1 = r1 >= d;
            g2 = r2 >= d;
            dv_r1_next[k] = g1 ? (CW+1)'(r1 - d) : r1[CW:0];
            dv_r2_next[k] = g2 ? (CW+1)'(r2 - d) : r2[CW:0];
            dv_n1_next[k] = {dv_n1_reg[k][NMW-2:0], g1};
            dv_n2_next[k] = {dv_n2_reg[k][NMW-2:0], g2};
        end
    end

    always_comb
    begin
        negb_ext = NSW'(sq_negb_reg[SW]);
        root_ext = signed'({2'b00, sq_root_reg[SW]});
        unique case (sq_kind_reg[SW])
            KIND_DISTINCT:
            begin
                num1 = negb_ext + root_ext;
                num2 = negb_ext - root_ext;
            end
            KIND_EQUAL:
            begin
                num1 = negb_ext;
                num2 = negb_ext;
            end
            KIND_COMPLEX:
            begin
                num1 = negb_ext;
                num2 = root_ext;
            end
            default:
            begin
                num1 = '0;
                num2 = '0;
            end
        endcase
        sat1 = saturate(dv_n1_reg[NMW], dv_s1_reg[NMW]);
        sat2 = saturate(dv_n2_reg[NMW], dv_s2_reg[NMW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SW; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= NMW; k++)
                dv_v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= in_valid;
            for (int k = 0; k < SW; k++)
                sq_v_reg[k+1] <= sq_v_reg[k];
            dv_v_reg[0] <= sq_v_reg[SW];
            for (int k = 0; k < NMW; k++)
                dv_v_reg[k+1] <= dv_v_reg[k];
            out_v_reg <= dv_v_reg[NMW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_kind_reg[0] <= kind;
            sq_rad_reg[0]  <= RW'({1'b0, disc_mag}) << (2 * FRAC_BITS);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_negb_reg[0] <= neg_lin;
            sq_aneg_reg[0] <= square_neg;
            sq_den_reg[0]  <= den_mag;
            for (int k = 0; k < SW; k++)
            begin
                sq_kind_reg[k+1] <= sq_kind_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_negb_reg[k+1] <= sq_negb_reg[k];
                sq_aneg_reg[k+1] <= sq_aneg_reg[k];
                sq_den_reg[k+1]  <= sq_den_reg[k];
            end

            // quotient sign is numerator sign against sign of a
            dv_kind_reg[0] <= sq_kind_reg[SW];
            dv_n1_reg[0]   <= num1[NSW-1] ? NMW'(-num1) : NMW'(num1);
            dv_n2_reg[0]   <= num2[NSW-1] ? NMW'(-num2) : NMW'(num2);
            dv_s1_reg[0]   <= num1[NSW-1] ^ sq_aneg_reg[SW];
            dv_s2_reg[0]   <= num2[NSW-1] ^ sq_aneg_reg[SW];
            dv_r1_reg[0]   <= '0;
            dv_r2_reg[0]   <= '0;
            dv_den_reg[0]  <= sq_den_reg[SW];
            for (int k = 0; k < NMW; k++)
            begin
                dv_kind_reg[k+1] <= dv_kind_reg[k];
                dv_n1_reg[k+1]   <= dv_n1_next[k];
                dv_n2_reg[k+1]   <= dv_n2_next[k];
                dv_r1_reg[k+1]   <= dv_r1_next[k];
                dv_r2_reg[k+1]   <= dv_r2_next[k];
                dv_s1_reg[k+1]   <= dv_s1_reg[k];
                dv_s2_reg[k+1]   <= dv_s2_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
            end

            out_kind_reg <= dv_kind_reg[NMW];
            if (dv_kind_reg[NMW] == KIND_NO_QUAD)
            begin
                out_first_reg  <= '0;
                out_second_reg <= '0;
            end
            else
            begin
                out_first_reg  <= sat1;
                out_second_reg <= sat2;
            end
        end
    end

    assign out_valid    = out_v_reg;
    assign root_kind    = out_kind_reg;
    assign first_value  = out_first_reg;
    assign second_value = out_second_reg;

endmodule

@@ hw/rtl/qrs_checker.sv @@
module qrs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [qrs_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input logic [1:0]                          m_axis_tuser
);
    import qrs_pkg::*;

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed under stall");

    // no leading coefficient gives zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_NO_QUAD |-> m_axis_tdata == '0)
        else $error("no-quadratic result carries nonzero values");

    // a double root is reported twice
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_EQUAL |->
            m_axis_tdata[OUT_WIDTH-1:0] == m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH])
        else $error("equal roots differ");

    // padding above the two values stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_WIDTH-1:2*OUT_WIDTH] == '0)
        else $error("tdata padding not zero");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/quadratic_root_solver_core_test.sv @@
`timescale 1ns / 1ps

module quadratic_root_solver_core_test;
    import qrs_pkg::*;

    localparam int OW = OUT_WIDTH;

    typedef struct {
        kind_t                kind;
        logic signed [OW-1:0] first;
        logic signed [OW-1:0] second;
    } roots_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [47:0]                s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
    logic [1:0]                 m_axis_tuser;

    roots_t expected_roots[$];
    int     error_count;
    bit     sink_hold;
    bit     sink_nowait;
    int     sink_wait;

    quadratic_root_solver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // coef_square, coef_linear, coef_constant
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // first_value, second_value
        .m_axis_tdata  (m_axis_tdata),
        // root_kind
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // floor sqrt of m << 32, bit by bit
    function automatic logic [63:0] fixed_sqrt(input logic [63:0] m);
        logic [127:0] rad;
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        rad = {64'd0, m} << 32;
        rem = '0;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
            root = root << 1;
            trial = 128'({root, 1'b1});
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic roots_t solve_roots(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic signed [15:0] c);
        roots_t r;
        longint disc;
        longint den;
        longint negb;
        longint s;
        disc = longint'(b) * b - 4 * longint'(a) * c;
        den = 2 * longint'(a);
        negb = -longint'(b) * 65536;
        if (a == 0)
        begin
            r.kind = KIND_NO_QUAD;
            r.first = '0;
            r.second = '0;
        end
        else if (disc > 0)
        begin
            s = longint'(fixed_sqrt(disc));
            r.kind = KIND_DISTINCT;
            r.first = OW'((negb + s) / den);
            r.second = OW'((negb - s) / den);
        end
        else if (disc == 0)
        begin
            r.kind = KIND_EQUAL;
            r.first = OW'(negb / den);
            r.second = r.first;
        end
        else
        begin
            s = longint'(fixed_sqrt(-disc));
            r.kind = KIND_COMPLEX;
            r.first = OW'(negb / den);
            r.second = OW'(s / den);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_roots.push_back(solve_roots(a, b, c));
    endtask

    // receiver side, a drawn wait before each transaction
    always @(posedge clk)
    begin
        if (!rst_n || sink_hold)
            m_axis_tready <= 1'b0;
        else if (sink_nowait)
            m_axis_tready <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            sink_wait = int'($urandom_range(0, 5));
            m_axis_tready <= (sink_wait == 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_roots.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                want = expected_roots.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("root_kind", m_axis_tuser, want.kind);
                if ($signed(m_axis_tdata[OW-1:0]) !== want.first)
                    report_mismatch("first_value", $signed(m_axis_tdata[OW-1:0]), want.first);
                if ($signed(m_axis_tdata[2*OW-1:OW]) !== want.second)
                    report_mismatch("second_value", $signed(m_axis_tdata[2*OW-1:OW]),
                                    want.second);
            end
        end
    end

    task automatic test_directed();
        logic [15:0] edges[6];
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5555};
        send_coefs(16'd0, 16'd5, 16'd7);          // leading coefficient zero
        send_coefs(16'd1, 16'hfffd, 16'd2);       // distinct real
        send_coefs(16'd1, 16'd2, 16'd1);          // equal real
        send_coefs(16'd1, 16'd0, 16'd1);          // complex
        send_coefs(16'hffff, 16'd0, 16'hffff);    // complex, negative a
        send_coefs(16'h8000, 16'h8000, 16'h7fff); // largest discriminant
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h0000, 16'h7fff); // negative discriminant, largest positive a and c
        send_coefs(16'h0001, 16'h7fff, 16'h0000);
        send_coefs(16'hffff, 16'h0002, 16'hffff); // equal, negative a
        for (int i = 0; i < 12; i++)
            send_coefs(edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                       edges[$urandom_range(0, 5)]);
    endtask

    task automatic test_random();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        int k;
        for (int i = 0; i < 400; i++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'($urandom);
            k = int'($urandom_range(0, 9));
            if (k == 0)
                a = '0;
            else if (k == 1)
                c = 16'(($signed(b) / 2) * ($signed(b) / 2) /
                        ($signed(a) == 0 ? 1 : $signed(a)));
            else if (k == 2)
            begin
                // a=1, b=2r; a perfect square with c=r*r when the drawn b is even
                a = 16'd1;
                b = 16'($urandom_range(0, 200)) - 16'd100;
                c = 16'($signed(b) / 2 * $signed(b) / 2);
                b = 16'($signed(b) / 2 * 2);
            end
            else if (k == 3)
            begin
                a = 16'($urandom_range(0, 15)) - 16'd8;
                b = 16'($urandom_range(0, 15)) - 16'd8;
                c = 16'($urandom_range(0, 15)) - 16'd8;
            end
            send_coefs(a, b, c);
        end
    endtask

    task automatic test_backpressure();
        int cnt;
        sink_hold = 1'b1;
        fork
            begin
                cnt = 0;
                while (cnt < 200)
                begin
                    @(posedge clk);
                    cnt++;
                end
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 120; i++)
                send_coefs(16'($urandom), 16'($urandom), 16'($urandom), 1);
        join
        sink_nowait = 1'b1;
        for (int i = 0; i < 20; i++)
            send_coefs(16'($urandom), 16'($urandom), 16'($urandom), 1);
        sink_nowait = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        sink_hold = 1'b0;
        sink_nowait = 1'b0;
        sink_wait = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
